FILE: design/stc_pkg.sv
// shared types, constants and arithmetic helpers for the self-tuning pseudo-clock
// no dependencies
package stc_pkg;

    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [15:0] RESYNC_INTERVAL_RESET = 16'd1000;
    localparam logic [15:0] IDLE_COUNT_MAX        = 16'hFFFF;
    localparam logic [30:0] SAT_LIMIT             = 31'h4000_0000;
    localparam logic [30:0] SAT_HALF              = 31'h2000_0000;

    localparam logic [1:0] MODE_ADAPTIVE   = 2'd0;
    localparam logic [1:0] MODE_EVERY_CALL = 2'd1;
    localparam logic [1:0] MODE_REAL       = 2'd2;

    typedef enum logic [1:0] {
        CFG_RESYNC_INTERVAL = 2'd0,
        CFG_CLOCK_MODE      = 2'd1,
        CFG_START_SECONDS   = 2'd2,
        CFG_START_MILLIS    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_RESYNC,
        KIND_STEP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] secs;
        logic [9:0]  millis;
    } t_entry;

    typedef struct packed {
        logic        valid;
        t_cfg_idx    idx;
        logic [31:0] data;
    } t_cfg_wr;

    // x * 1000 as x*1024 - x*16 - x*8, modulo 2^32
    function automatic logic [31:0] mul_k1000(input logic [31:0] x);
        return (x << 10) - (x << 4) - (x << 3);
    endfunction

    function automatic logic [30:0] dbl_sat(input logic [30:0] v);
        if (v >= SAT_HALF) begin
            return SAT_LIMIT;
        end
        return v << 1;
    endfunction

endpackage

FILE: design/stc_fifo.sv
// short word queue between the call classifier and the clock update unit
// depends on stc_pkg
module stc_fifo
    import stc_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    input  logic   i_pop,
    output t_entry o_data,
    output logic   o_full,
    output logic   o_not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wptr  = i_push ? ptr_inc(r_wptr) : r_wptr;
        n_rptr  = i_pop ? ptr_inc(r_rptr) : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data      = r_mem[r_rptr];
    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);

endmodule

FILE: design/stc_front.sv
// call classifier: keeps the call counters and decides step, resync or direct
// depends on stc_pkg
module stc_front
    import stc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [31:0] i_now_seconds,
    input  logic [9:0]  i_now_millis,
    input  logic        i_from_idle,
    input  t_cfg_wr     i_cfg,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [15:0] r_interval, n_interval;
    logic [1:0]  r_mode, n_mode;
    logic [15:0] r_since_resync, n_since_resync;
    logic [15:0] r_since_idle, n_since_idle;

    logic        idle_hit;
    logic [15:0] resync_inc;
    t_kind       kind;

    always_comb begin
        n_interval     = r_interval;
        n_mode         = r_mode;
        n_since_resync = r_since_resync;
        n_since_idle   = r_since_idle;
        idle_hit       = 1'b0;
        resync_inc     = r_since_resync + 16'd1;
        kind           = KIND_STEP;

        if (r_mode == MODE_REAL) begin
            kind = KIND_DIRECT;
        end else if (r_mode == MODE_EVERY_CALL) begin
            kind = KIND_RESYNC;
        end else begin
            if (i_from_idle) begin
                idle_hit = (r_since_idle == '0);
            end
            if (resync_inc >= r_interval || idle_hit) begin
                kind = KIND_RESYNC;
            end
            if (i_accept) begin
                if (i_from_idle) begin
                    n_since_idle = '0;
                end else if (r_since_idle != IDLE_COUNT_MAX) begin
                    n_since_idle = r_since_idle + 16'd1;
                end
                n_since_resync = (kind == KIND_RESYNC) ? '0 : resync_inc;
            end
        end

        if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                CFG_RESYNC_INTERVAL: n_interval = i_cfg.data[15:0];
                CFG_CLOCK_MODE:      n_mode     = i_cfg.data[1:0];
                CFG_START_SECONDS, CFG_START_MILLIS: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval     <= RESYNC_INTERVAL_RESET;
            r_mode         <= MODE_ADAPTIVE;
            r_since_resync <= '0;
            r_since_idle   <= '0;
        end else begin
            r_interval     <= n_interval;
            r_mode         <= n_mode;
            r_since_resync <= n_since_resync;
            r_since_idle   <= n_since_idle;
        end
    end

    assign o_push         = i_accept;
    assign o_entry.kind   = kind;
    assign o_entry.secs   = i_now_seconds;
    assign o_entry.millis = i_now_millis;

endmodule

FILE: design/stc_back.sv
// clock update unit: pseudo-clock, snapshot, rate tuning and the output word register
// depends on stc_pkg
module stc_back
    import stc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_entry             i_entry,
    input  logic               i_not_empty,
    output logic               o_pop,
    input  t_cfg_wr            i_cfg,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_clock_value,
    output logic               o_resynced,
    output logic signed [31:0] o_drift_applied
);

    logic [31:0] r_pseudo, n_pseudo;
    logic [31:0] r_snap_seconds, n_snap_seconds;
    logic [9:0]  r_snap_millis, n_snap_millis;
    logic [31:0] r_snap_count, n_snap_count;
    logic [30:0] r_since_step, n_since_step;
    logic [30:0] r_step, n_step;
    logic [30:0] r_cps, n_cps;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_clock_value, n_clock_value;
    logic        r_resynced, n_resynced;
    logic [31:0] r_drift, n_drift;

    logic [31:0] milli_diff;
    logic [31:0] secs_delta;
    logic [31:0] elapsed;
    logic [31:0] drift;
    logic [31:0] resync_pseudo;
    logic [30:0] step_inc;

    assign o_pop = i_not_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        milli_diff = {22'd0, i_entry.millis} - {22'd0, r_snap_millis};
        secs_delta = i_entry.secs - r_snap_seconds;
        if (!secs_delta[31]) begin
            elapsed = milli_diff + mul_k1000(secs_delta);
        end else if (milli_diff[31]) begin
            elapsed = '0;
        end else begin
            elapsed = milli_diff;
        end
        drift         = elapsed - (r_pseudo - r_snap_count);
        resync_pseudo = r_pseudo + drift;
        step_inc      = r_since_step + 31'd1;
    end

    always_comb begin
        n_pseudo       = r_pseudo;
        n_snap_seconds = r_snap_seconds;
        n_snap_millis  = r_snap_millis;
        n_snap_count   = r_snap_count;
        n_since_step   = r_since_step;
        n_step         = r_step;
        n_cps          = r_cps;
        n_clock_value  = r_clock_value;
        n_resynced     = r_resynced;
        n_drift        = r_drift;
        n_out_valid    = r_out_valid && i_out_stall;

        if (o_pop) begin
            n_out_valid = 1'b1;
            unique case (i_entry.kind)
                KIND_DIRECT: begin
                    n_clock_value = mul_k1000(i_entry.secs) + {22'd0, i_entry.millis};
                    n_resynced    = 1'b0;
                    n_drift       = '0;
                end
                KIND_RESYNC: begin
                    if (drift[31]) begin
                        if (r_step == 31'd1) begin
                            n_cps = dbl_sat(r_cps);
                        end else begin
                            n_step = r_step >> 1;
                        end
                    end else if (drift != '0) begin
                        if (r_cps == 31'd1) begin
                            n_step = dbl_sat(r_step);
                        end else begin
                            n_cps = r_cps >> 1;
                        end
                    end
                    n_pseudo       = resync_pseudo;
                    n_snap_seconds = i_entry.secs;
                    n_snap_millis  = i_entry.millis;
                    n_snap_count   = resync_pseudo;
                    n_clock_value  = resync_pseudo;
                    n_resynced     = 1'b1;
                    n_drift        = drift;
                end
                KIND_STEP: begin
                    if (step_inc >= r_cps) begin
                        n_since_step  = '0;
                        n_pseudo      = r_pseudo + {1'b0, r_step};
                        n_clock_value = r_pseudo + {1'b0, r_step};
                    end else begin
                        n_since_step  = step_inc;
                        n_clock_value = r_pseudo;
                    end
                    n_resynced = 1'b0;
                    n_drift    = '0;
                end
                default: begin
                end
            endcase
        end

        // start time writes also load the snapshot
        if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                CFG_START_SECONDS: n_snap_seconds = i_cfg.data;
                CFG_START_MILLIS:  n_snap_millis  = i_cfg.data[9:0];
                CFG_RESYNC_INTERVAL, CFG_CLOCK_MODE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pseudo       <= '0;
            r_snap_seconds <= '0;
            r_snap_millis  <= '0;
            r_snap_count   <= '0;
            r_since_step   <= '0;
            r_step         <= 31'd1;
            r_cps          <= 31'd1;
            r_out_valid    <= 1'b0;
        end else begin
            r_pseudo       <= n_pseudo;
            r_snap_seconds <= n_snap_seconds;
            r_snap_millis  <= n_snap_millis;
            r_snap_count   <= n_snap_count;
            r_since_step   <= n_since_step;
            r_step         <= n_step;
            r_cps          <= n_cps;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clock_value <= n_clock_value;
        r_resynced    <= n_resynced;
        r_drift       <= n_drift;
    end

    assign o_out_valid     = r_out_valid;
    assign o_clock_value   = r_clock_value;
    assign o_resynced      = r_resynced;
    assign o_drift_applied = r_drift;

endmodule

FILE: design/self_tuning_pseudo_clock.sv
// top level of the self-tuning pseudo-clock: classifier, word queue and update unit
// depends on stc_pkg, stc_front, stc_fifo and stc_back
//
// Takes one scheduler call word per cycle while o_in_stall is low and returns one result word per
// call, in order. A call is classified on acceptance (step, resync or real-time direct) by the
// call counters, passes a queue of FIFO_DEPTH words, and the update unit applies it to the
// pseudo-clock: one constant multiply by 1000 done as shifts, then the drift adds. The result
// word is registered in the output word register after the call leaves the queue; o_in_stall
// rises only when the queue is full behind a stalled result. Configuration writes are taken
// every cycle (o_cfg_ready is tied high); writing a start time also loads the resync snapshot.
module self_tuning_pseudo_clock
    import stc_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH_P = FIFO_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_now_seconds,
    input  logic [9:0]         i_now_millis,
    input  logic               i_from_idle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_clock_value,
    output logic               o_resynced,
    output logic signed [31:0] o_drift_applied,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cfg_wr cfg;
    t_entry  push_entry;
    t_entry  head_entry;
    logic    push;
    logic    pop;
    logic    full;
    logic    not_empty;
    logic    accept;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.idx     = t_cfg_idx'(i_cfg_index);
    assign cfg.data    = i_cfg_data;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    stc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_now_seconds (i_now_seconds),
        .i_now_millis  (i_now_millis),
        .i_from_idle   (i_from_idle),
        .i_cfg         (cfg),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    stc_fifo #(
        .DEPTH (FIFO_DEPTH_P)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (push_entry),
        .i_pop       (pop),
        .o_data      (head_entry),
        .o_full      (full),
        .o_not_empty (not_empty)
    );

    stc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (head_entry),
        .i_not_empty     (not_empty),
        .o_pop           (pop),
        .i_cfg           (cfg),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_clock_value   (o_clock_value),
        .o_resynced      (o_resynced),
        .o_drift_applied (o_drift_applied)
    );

endmodule

FILE: design/stc_checker.sv
// port-level checks for the self-tuning pseudo-clock, bound to the top level
// depends on self_tuning_pseudo_clock
module stc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [31:0]        i_now_seconds,
    input logic [9:0]         i_now_millis,
    input logic               i_from_idle,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_clock_value,
    input logic               o_resynced,
    input logic signed [31:0] o_drift_applied,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic [1:0]         i_cfg_index,
    input logic [31:0]        i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_no_drift_without_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_resynced |-> o_drift_applied == 32'sd0)
        else $error("drift reported without resync");

    a_stall_only_when_backed_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

endmodule

bind self_tuning_pseudo_clock stc_checker u_stc_checker (.*);

FILE: tb/tb_self_tuning_pseudo_clock.sv
// self-checking testbench for the self-tuning pseudo-clock: directed and random scheduler calls
// with random stalls on both sides, checked word by word against a behavioural clock model
// depends on stc_pkg and self_tuning_pseudo_clock
module tb_self_tuning_pseudo_clock
    import stc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        logic [31:0] secs;
        logic [9:0]  millis;
        logic        idle;
    } t_call;

    typedef struct {
        logic signed [31:0] value;
        logic               resynced;
        logic signed [31:0] drift;
    } t_clock_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [31:0] i_now_seconds = '0;
    logic [9:0] i_now_millis = '0;
    logic i_from_idle = 1'b0;
    logic i_out_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [31:0] o_clock_value;
    logic o_resynced;
    logic signed [31:0] o_drift_applied;
    logic o_cfg_ready;

    self_tuning_pseudo_clock dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_now_seconds   (i_now_seconds),
        .i_now_millis    (i_now_millis),
        .i_from_idle     (i_from_idle),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_clock_value   (o_clock_value),
        .o_resynced      (o_resynced),
        .o_drift_applied (o_drift_applied),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // model state
    logic [15:0] resync_every;
    logic [1:0]  mode;
    logic [31:0] pseudo_ms;
    logic [31:0] snap_secs;
    logic [9:0]  snap_ms;
    logic [31:0] snap_pseudo;
    logic [15:0] since_resync;
    logic [30:0] since_tick;
    logic [15:0] idle_gap;
    logic [30:0] tick_ms;
    logic [30:0] calls_per_tick;

    t_call       pending_calls[$];
    t_clock_word due_words[$];
    t_call       next_call;
    t_clock_word due;
    bit          in_taken = 1'b0;
    bit          quiet = 1'b0;
    bit          pressure_req = 1'b0;
    bit          hold_used = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          cycles = 0;
    logic [31:0] wall_secs = '0;
    int          wall_ms = 0;

    function automatic logic [30:0] doubled_capped(logic [30:0] v);
        return (v >= SAT_HALF) ? SAT_LIMIT : {v[29:0], 1'b0};
    endfunction

    function automatic logic [31:0] resync_to(logic [31:0] secs, logic [9:0] ms);
        logic [31:0] elapsed;
        logic [31:0] sdiff;
        logic [31:0] drift;
        elapsed = {22'd0, ms} - {22'd0, snap_ms};
        sdiff = secs - snap_secs;
        if (!sdiff[31]) begin
            elapsed = elapsed + sdiff * 32'd1000;
        end else if (elapsed[31]) begin
            elapsed = '0;
        end
        drift = elapsed - (pseudo_ms - snap_pseudo);
        if (drift[31]) begin
            if (tick_ms == 31'd1) calls_per_tick = doubled_capped(calls_per_tick);
            else tick_ms = tick_ms >> 1;
        end else if (drift != '0) begin
            if (calls_per_tick == 31'd1) tick_ms = doubled_capped(tick_ms);
            else calls_per_tick = calls_per_tick >> 1;
        end
        pseudo_ms = pseudo_ms + drift;
        snap_secs = secs;
        snap_ms = ms;
        snap_pseudo = pseudo_ms;
        return drift;
    endfunction

    function automatic t_clock_word clock_after_call(t_call c);
        t_clock_word r;
        logic idle_resync;
        r.resynced = 1'b0;
        r.drift = '0;
        if (mode == MODE_REAL) begin
            r.value = c.secs * 32'd1000 + {22'd0, c.millis};
            return r;
        end
        if (mode == MODE_EVERY_CALL) begin
            r.drift = resync_to(c.secs, c.millis);
            r.resynced = 1'b1;
        end else begin
            idle_resync = 1'b0;
            if (c.idle) begin
                idle_resync = (idle_gap == '0);
                idle_gap = '0;
            end else if (idle_gap != IDLE_COUNT_MAX) begin
                idle_gap = idle_gap + 16'd1;
            end
            since_resync = since_resync + 16'd1;
            if (since_resync >= resync_every || idle_resync) begin
                since_resync = '0;
                r.drift = resync_to(c.secs, c.millis);
                r.resynced = 1'b1;
            end else begin
                since_tick = since_tick + 31'd1;
                if (since_tick >= calls_per_tick) begin
                    since_tick = '0;
                    pseudo_ms = pseudo_ms + {1'b0, tick_ms};
                end
            end
        end
        r.value = pseudo_ms;
        return r;
    endfunction

    function automatic void clock_reset();
        resync_every = RESYNC_INTERVAL_RESET;
        mode = MODE_ADAPTIVE;
        pseudo_ms = '0;
        snap_secs = '0;
        snap_ms = '0;
        snap_pseudo = '0;
        since_resync = '0;
        since_tick = '0;
        idle_gap = '0;
        tick_ms = 31'd1;
        calls_per_tick = 31'd1;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, seen);
        end
    endtask

    // monitor: model update on accepted words, result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_in_valid && !o_in_stall;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_RESYNC_INTERVAL: resync_every = i_cfg_data[15:0];
                    CFG_CLOCK_MODE:      mode = i_cfg_data[1:0];
                    CFG_START_SECONDS:   snap_secs = i_cfg_data;
                    CFG_START_MILLIS:    snap_ms = i_cfg_data[9:0];
                endcase
            end
            if (in_taken)
                due_words.push_back(clock_after_call('{i_now_seconds, i_now_millis, i_from_idle}));
            if (o_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with none expected: value %h", o_clock_value);
                end else begin
                    due = due_words.pop_front();
                    check_field("clock_value", due.value, o_clock_value);
                    check_field("resynced", {31'd0, due.resynced}, {31'd0, o_resynced});
                    check_field("drift_applied", due.drift, o_drift_applied);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("self_tuning_pseudo_clock test failed");
            $finish;
        end
    end

    // call driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_calls.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
                next_call = pending_calls.pop_front();
                i_in_valid <= 1'b1;
                i_now_seconds <= next_call.secs;
                i_now_millis <= next_call.millis;
                i_from_idle <= next_call.idle;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall, with one long hold-off to fill the queue
    always @(negedge i_clk) begin
        if (pressure_req && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 9);
        end
    end

    task automatic add_call(logic [31:0] secs, logic [9:0] ms, logic idle);
        t_call c;
        c.secs = secs;
        c.millis = ms;
        c.idle = idle;
        pending_calls.push_back(c);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_calls.size() != 0 || i_in_valid || due_words.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly advancing real time, with jumps back, huge jumps and noise words
    task automatic queue_traffic(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                add_call($urandom, 10'($urandom_range(1023)), 1'($urandom_range(1)));
            end else begin
                if (r < 10) begin
                    wall_secs = wall_secs - $urandom_range(2);
                end else if (r < 13) begin
                    wall_ms = $urandom_range(999);
                end else if (r < 16) begin
                    wall_secs = wall_secs + $urandom;
                end else begin
                    wall_ms = wall_ms + $urandom_range(4);
                    if (wall_ms >= 1000) begin
                        wall_ms = wall_ms - 1000;
                        wall_secs = wall_secs + 1;
                    end
                end
                add_call(wall_secs, 10'(wall_ms), $urandom_range(99) < 25);
            end
        end
    endtask

    initial begin
        int r;
        clock_reset();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle pairs, extremes of time
        add_call(32'd0, 10'd0, 1'b0);
        add_call(32'd0, 10'd0, 1'b1);
        add_call(32'd0, 10'd0, 1'b1);
        add_call(32'd0, 10'd999, 1'b0);
        add_call(32'd1, 10'd1023, 1'b1);
        add_call(32'hFFFF_FFFF, 10'd999, 1'b0);
        add_call(32'hFFFF_FFFF, 10'd0, 1'b1);
        add_call(32'h8000_0000, 10'd500, 1'b1);
        add_call(32'h8000_0000, 10'd500, 1'b1);
        wait_drained();

        write_reg(CFG_CLOCK_MODE, {30'd0, MODE_EVERY_CALL});
        write_reg(CFG_START_SECONDS, 32'hFFFF_FFFF);
        write_reg(CFG_START_MILLIS, 32'd999);
        add_call(32'd0, 10'd0, 1'b0);
        add_call(32'd0, 10'd0, 1'b0);
        add_call(32'd0, 10'd1023, 1'b1);
        add_call(32'h7FFF_FFFF, 10'd0, 1'b0);
        add_call(32'h7FFF_FFFF, 10'd0, 1'b0);
        add_call(32'd0, 10'd5, 1'b0);
        wait_drained();

        write_reg(CFG_CLOCK_MODE, {30'd0, MODE_REAL});
        add_call(32'hFFFF_FFFF, 10'd1023, 1'b1);
        add_call(32'd0, 10'd0, 1'b0);
        add_call(32'h0041_8937, 10'd999, 1'b0);
        wait_drained();

        // undefined mode falls back to adaptive, zero interval resyncs every call
        write_reg(CFG_CLOCK_MODE, 32'd3);
        write_reg(CFG_RESYNC_INTERVAL, 32'd0);
        write_reg(CFG_START_SECONDS, 32'd0);
        write_reg(CFG_START_MILLIS, 32'd1023);
        add_call(32'd0, 10'd0, 1'b0);
        add_call(32'd0, 10'd1023, 1'b0);
        add_call(32'd5, 10'd0, 1'b1);
        add_call(32'd5, 10'd0, 1'b1);
        wait_drained();

        write_reg(CFG_RESYNC_INTERVAL, 32'hABCD_FFFF);
        write_reg(CFG_CLOCK_MODE, {30'd0, MODE_ADAPTIVE});
        add_call(32'd10, 10'd0, 1'b0);
        add_call(32'd10, 10'd1, 1'b0);
        wait_drained();

        wall_secs = $urandom;
        wall_ms = $urandom_range(999);
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(5))
                0: write_reg(CFG_RESYNC_INTERVAL, 32'd1);
                1: write_reg(CFG_RESYNC_INTERVAL, 32'd2);
                2: write_reg(CFG_RESYNC_INTERVAL, $urandom_range(3, 20));
                3: write_reg(CFG_RESYNC_INTERVAL, $urandom_range(21, 300));
                4: write_reg(CFG_RESYNC_INTERVAL, 32'd0);
                default: write_reg(CFG_RESYNC_INTERVAL, 32'd65535);
            endcase
            r = $urandom_range(99);
            if (r < 60) write_reg(CFG_CLOCK_MODE, {30'd0, MODE_ADAPTIVE});
            else if (r < 75) write_reg(CFG_CLOCK_MODE, {30'd0, MODE_EVERY_CALL});
            else if (r < 90) write_reg(CFG_CLOCK_MODE, {30'd0, MODE_REAL});
            else write_reg(CFG_CLOCK_MODE, 32'd3);
            if ($urandom_range(1)) begin
                write_reg(CFG_START_SECONDS, wall_secs - $urandom_range(3));
                write_reg(CFG_START_MILLIS, $urandom_range(1023));
            end
            if (p == 3) pressure_req = 1'b1;
            queue_traffic(25);
            wait_drained();
        end

        // step doubles up to saturation, then halves back and calls per step saturate
        write_reg(CFG_CLOCK_MODE, {30'd0, MODE_EVERY_CALL});
        for (int i = 0; i < 64; i++) begin
            wall_secs = wall_secs + $urandom_range(1000, 4000);
            add_call(wall_secs, 10'(wall_ms), 1'($urandom_range(1)));
        end
        for (int i = 0; i < 70; i++)
            add_call(wall_secs, 10'(1023 - i), 1'($urandom_range(1)));
        wait_drained();

        // long run with no idling at the widest interval, then idle pairs
        quiet = 1'b1;
        write_reg(CFG_CLOCK_MODE, {30'd0, MODE_ADAPTIVE});
        write_reg(CFG_RESYNC_INTERVAL, 32'd65535);
        add_call(wall_secs, 10'(wall_ms), 1'b1);
        for (int i = 0; i < 40; i++) begin
            wall_ms = wall_ms + $urandom_range(2);
            if (wall_ms >= 1000) begin
                wall_ms = wall_ms - 1000;
                wall_secs = wall_secs + 1;
            end
            add_call(wall_secs, 10'(wall_ms), 1'b0);
        end
        add_call(wall_secs, 10'(wall_ms), 1'b1);
        add_call(wall_secs, 10'(wall_ms), 1'b1);
        add_call(wall_secs + 1, 10'(wall_ms), 1'b0);
        wait_drained();
        quiet = 1'b0;

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && due_words.size() == 0) begin
            $display("self_tuning_pseudo_clock test passed");
        end else begin
            $display("self_tuning_pseudo_clock test failed");
        end
        $finish;
    end

endmodule
